/* hdl/btt_pkg.sv */
// Package for the bearing unit: formats, constants, angle table and the stage data type.
package btt_pkg;

  // Coordinate width taken from the input ports, and CORDIC depth
  localparam int COORD_WIDTH     = 16;
  localparam int CORDIC_STAGES   = 14;

  // Derived formats
  localparam int PRESCALE        = 56 - COORD_WIDTH;
  localparam int DIFF_W          = COORD_WIDTH + 1;
  localparam int DW              = DIFF_W + PRESCALE + 3;
  localparam int ZW              = 33;
  localparam int QW              = 34;
  localparam int RW              = QW + 1 - 17;
  localparam int ANGLE_TABLE_LEN = 24;
  localparam int IDX_W           = $clog2(ANGLE_TABLE_LEN);

  // Output angles, Q3.13
  localparam logic [15:0] PI_BY_2       = 16'd12868;
  localparam logic [15:0] THREE_PI_BY_2 = 16'd38604;
  localparam logic [15:0] PI            = 16'd25736;
  localparam logic [15:0] TWO_PI        = 16'd51472;

  // Angles in Q30
  localparam logic signed [ZW-1:0] PI_BY_2_Q30 = ZW'(64'sd1686629713);
  localparam logic [QW-1:0]        PI_Q30      = QW'(64'd3373259426);
  localparam logic [QW-1:0]        TWO_PI_Q30  = QW'(64'd6746518852);
  localparam logic [QW-1:0]        HALF_LSB    = QW'(64'd65536);

  // Data handed from cell to cell
  typedef struct packed {
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 dx_zero;
    logic                 dx_neg;
    logic                 dy_neg;
    logic                 dy_pos;
  } btt_vec_t;

  // atan(2^-i) in Q30, rounded to nearest
  function automatic logic signed [ZW-1:0] atan_q30(input logic [IDX_W-1:0] idx);
    logic signed [ZW-1:0] v;
    case (idx)
      5'd0:    v = ZW'(64'sd843314857);
      5'd1:    v = ZW'(64'sd497837829);
      5'd2:    v = ZW'(64'sd263043837);
      5'd3:    v = ZW'(64'sd133525159);
      5'd4:    v = ZW'(64'sd67021687);
      5'd5:    v = ZW'(64'sd33543516);
      5'd6:    v = ZW'(64'sd16775851);
      5'd7:    v = ZW'(64'sd8388437);
      5'd8:    v = ZW'(64'sd4194283);
      5'd9:    v = ZW'(64'sd2097149);
      5'd10:   v = ZW'(64'sd1048576);
      5'd11:   v = ZW'(64'sd524288);
      5'd12:   v = ZW'(64'sd262144);
      5'd13:   v = ZW'(64'sd131072);
      5'd14:   v = ZW'(64'sd65536);
      5'd15:   v = ZW'(64'sd32768);
      5'd16:   v = ZW'(64'sd16384);
      5'd17:   v = ZW'(64'sd8192);
      5'd18:   v = ZW'(64'sd4096);
      5'd19:   v = ZW'(64'sd2048);
      5'd20:   v = ZW'(64'sd1024);
      5'd21:   v = ZW'(64'sd512);
      5'd22:   v = ZW'(64'sd256);
      5'd23:   v = ZW'(64'sd128);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* hdl/btt_prep.sv */
// Entry stage: coordinate differences, magnitudes, quadrant flags and prescale.
module btt_prep (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                up_valid,
  output logic                                up_ready,
  input  logic signed [15:0]                  self_x,
  input  logic signed [15:0]                  self_y,
  input  logic signed [15:0]                  target_x,
  input  logic signed [15:0]                  target_y,
  output logic                                dn_valid,
  input  logic                                dn_ready,
  output btt_pkg::btt_vec_t                   dn_vec
);
  import btt_pkg::*;

  logic signed [COORD_WIDTH-1:0] sx, sy, tx, ty;
  logic signed [DIFF_W-1:0]      dx, dy;
  logic [DIFF_W-1:0]             ax, ay;
  logic                          valid_r;
  btt_vec_t                      vec_r, vec_nxt;

  // Bits above the coordinate width are dropped, narrower ports sign-extend
  assign sx = COORD_WIDTH'(self_x);
  assign sy = COORD_WIDTH'(self_y);
  assign tx = COORD_WIDTH'(target_x);
  assign ty = COORD_WIDTH'(target_y);

  assign dx = DIFF_W'(tx) - DIFF_W'(sx);
  assign dy = DIFF_W'(ty) - DIFF_W'(sy);
  assign ax = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
  assign ay = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);

  // Scaled first-quadrant vector and flags for the final correction
  always_comb begin
    vec_nxt.x       = {{(DW-DIFF_W-PRESCALE){1'b0}}, ax, {PRESCALE{1'b0}}};
    vec_nxt.y       = {{(DW-DIFF_W-PRESCALE){1'b0}}, ay, {PRESCALE{1'b0}}};
    vec_nxt.z       = '0;
    vec_nxt.dx_zero = (dx == '0);
    vec_nxt.dx_neg  = dx[DIFF_W-1];
    vec_nxt.dy_neg  = dy[DIFF_W-1];
    vec_nxt.dy_pos  = !dy[DIFF_W-1] && (dy != '0);
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      vec_r <= vec_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_vec   = vec_r;

endmodule

/* hdl/btt_cell.sv */
// One CORDIC vectoring cell: a rotation by atan(2^-i) and its pipeline register.
module btt_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [btt_pkg::IDX_W-1:0]   stage_idx,
  input  logic                        up_valid,
  output logic                        up_ready,
  input  btt_pkg::btt_vec_t           up_vec,
  output logic                        dn_valid,
  input  logic                        dn_ready,
  output btt_pkg::btt_vec_t           dn_vec
);
  import btt_pkg::*;

  logic signed [DW-1:0] xs, ys;
  logic signed [ZW-1:0] ang;
  logic                 valid_r;
  btt_vec_t             vec_r, vec_nxt;

  assign xs  = up_vec.x >>> stage_idx;
  assign ys  = up_vec.y >>> stage_idx;
  assign ang = atan_q30(stage_idx);

  // Rotate towards the x axis; sign of y picks the direction
  always_comb begin
    vec_nxt = up_vec;
    if (!up_vec.y[DW-1]) begin
      vec_nxt.x = up_vec.x + ys;
      vec_nxt.y = up_vec.y - xs;
      vec_nxt.z = up_vec.z + ang;
    end else begin
      vec_nxt.x = up_vec.x - ys;
      vec_nxt.y = up_vec.y + xs;
      vec_nxt.z = up_vec.z - ang;
    end
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      vec_r <= vec_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_vec   = vec_r;

endmodule

/* hdl/btt_final.sv */
// Exit stage: angle clamp, quadrant correction, rounding to Q3.13 and output register.
module btt_final (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_ready,
  input  btt_pkg::btt_vec_t  up_vec,
  output logic               dn_valid,
  input  logic               dn_stall,
  output logic [15:0]        bearing
);
  import btt_pkg::*;

  logic signed [ZW-1:0] zc;
  logic [QW-1:0]        a, q;
  logic [QW:0]          sum;
  logic [RW-1:0]        rnd;
  logic [15:0]          bearing_nxt, bearing_r;
  logic                 valid_r;

  // Clamp first-quadrant angle to [0, pi/2]
  always_comb begin
    if (up_vec.z[ZW-1]) begin
      zc = '0;
    end else if (up_vec.z > PI_BY_2_Q30) begin
      zc = PI_BY_2_Q30;
    end else begin
      zc = up_vec.z;
    end
  end

  assign a = QW'($unsigned(zc));

  // Quadrant correction
  always_comb begin
    if (!up_vec.dx_neg) begin
      q = up_vec.dy_neg ? (TWO_PI_Q30 - a) : a;
    end else begin
      q = up_vec.dy_neg ? (PI_Q30 + a) : (PI_Q30 - a);
    end
  end

  // Round Q30 to Q3.13, wrap full circle; vertical case takes priority
  assign sum = {1'b0, q} + {1'b0, HALF_LSB};
  assign rnd = sum[QW:17];

  always_comb begin
    if (up_vec.dx_zero) begin
      bearing_nxt = up_vec.dy_pos ? PI_BY_2 : THREE_PI_BY_2;
    end else if (rnd >= RW'(TWO_PI)) begin
      bearing_nxt = '0;
    end else begin
      bearing_nxt = rnd[15:0];
    end
  end

  assign up_ready = !valid_r || !dn_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      bearing_r <= bearing_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign bearing  = bearing_r;

endmodule

/* hdl/bearing_to_target_unit.sv */
// Path of an item: entry register, one register per CORDIC cell, output register.
// Throughput: one item per cycle unless stalled; entry stage, CORDIC cells and output
// register hold one item each; stalled output only holds items where the chain is full.
// Reset: synchronous, active low; clears every stage's valid flag, data is not reset.
// Top level of the bearing unit: entry stage, chain of CORDIC cells, exit stage.
module bearing_to_target_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_self_x,
  input  logic signed [15:0] in_self_y,
  input  logic signed [15:0] in_target_x,
  input  logic signed [15:0] in_target_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_bearing
);
  import btt_pkg::*;

  btt_vec_t vec   [CORDIC_STAGES+1];
  logic     valid [CORDIC_STAGES+1];
  logic     ready [CORDIC_STAGES+1];
  logic     prep_ready;

  assign in_stall = !prep_ready;

  // Entry stage
  btt_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (prep_ready),
    .self_x   (in_self_x),
    .self_y   (in_self_y),
    .target_x (in_target_x),
    .target_y (in_target_y),
    .dn_valid (valid[0]),
    .dn_ready (ready[0]),
    .dn_vec   (vec[0])
  );

  // CORDIC chain, one cell per iteration
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    btt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .stage_idx (IDX_W'(i)),
      .up_valid  (valid[i]),
      .up_ready  (ready[i]),
      .up_vec    (vec[i]),
      .dn_valid  (valid[i+1]),
      .dn_ready  (ready[i+1]),
      .dn_vec    (vec[i+1])
    );
  end

  // Exit stage
  btt_final u_final (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (valid[CORDIC_STAGES]),
    .up_ready (ready[CORDIC_STAGES]),
    .up_vec   (vec[CORDIC_STAGES]),
    .dn_valid (out_valid),
    .dn_stall (out_stall),
    .bearing  (out_bearing)
  );

endmodule

/* hdl/btt_checker.sv */
// Port-level checks for the bearing unit and their bind to the top level.
module btt_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic signed [15:0] in_self_x,
  input logic signed [15:0] in_self_y,
  input logic signed [15:0] in_target_x,
  input logic signed [15:0] in_target_y,
  input logic               out_valid,
  input logic               out_stall,
  input logic [15:0]        out_bearing
);
  import btt_pkg::*;

  // A stalled input item keeps its payload
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid &&
      $stable({in_self_x, in_self_y, in_target_x, in_target_y}))
    else $error("stalled input item changed");

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_bearing))
    else $error("stalled result changed");

  // Bearing always lies below a full circle
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_bearing < TWO_PI)
    else $error("bearing outside [0, 2pi)");

  // Reset empties the pipeline
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A free output leaves the whole chain free, so input is never held
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input held while output is free");

endmodule

bind bearing_to_target_unit btt_checker u_btt_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .in_self_x   (in_self_x),
  .in_self_y   (in_self_y),
  .in_target_x (in_target_x),
  .in_target_y (in_target_y),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_bearing (out_bearing)
);
